// ===== sv/psm_pkg.sv =====
`default_nettype none

package psm_pkg;

    // Fixed field and register widths.
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned LEN_W         = 6;
    localparam int unsigned CFG_DATA_W    = 64;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned START_W       = 16;
    localparam int unsigned NUM_PAT_REGS  = 4;
    localparam int unsigned NUM_PAT_BYTES = 32;
    localparam int unsigned PAT_BITS_W    = NUM_PAT_BYTES * BYTE_W;
    localparam int unsigned PAT_IDX_W     = 7;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LENGTH = 3'd0,
        CFG_PAT_0_7    = 3'd1,
        CFG_PAT_8_15   = 3'd2,
        CFG_PAT_16_23  = 3'd3,
        CFG_PAT_24_31  = 3'd4
    } cfg_idx_t;

    // Per-cell control: shift the window, and clear it for a new text.
    typedef struct packed {
        logic shift;
        logic flush;
    } cell_ctl_t;

    // One result item as it travels to the output buffer.
    typedef struct packed {
        logic               match_found;
        logic [START_W-1:0] match_start;
        logic               position_overflow;
    } psm_result_t;

    // Pattern byte j; bytes past the register file read as zero.
    function automatic logic [BYTE_W-1:0] pat_byte(
        input logic [PAT_BITS_W-1:0] bits,
        input logic [PAT_IDX_W-1:0]  j
    );
        logic [BYTE_W-1:0] val;
        if (j >= PAT_IDX_W'(NUM_PAT_BYTES)) begin
            val = '0;
        end else begin
            val = bits[{j[4:0], 3'b000} +: BYTE_W];
        end
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== sv/psm_cell.sv =====
`default_nettype none

module psm_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire psm_pkg::cell_ctl_t        ctl,
    input  wire logic [psm_pkg::BYTE_W-1:0] d_in,
    input  wire logic [psm_pkg::BYTE_W-1:0] pat,
    input  wire logic                      in_use,
    output logic      [psm_pkg::BYTE_W-1:0] q_out,
    output logic                           hit
);
    import psm_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // Value this cell takes on the transfer: neighbor's byte, or zero on a new text.
    always_comb begin
        byte_next = ctl.flush ? '0 : d_in;
    end

    // Window byte register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else if (ctl.shift) begin
            byte_reg <= byte_next;
        end
    end

    // Compare against the aligned pattern byte; unused cells always agree.
    always_comb begin
        hit = !in_use || (byte_next == pat);
    end

    assign q_out = byte_reg;

endmodule

`default_nettype wire

// ===== sv/psm_out_buf.sv =====
`default_nettype none

module psm_out_buf (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire psm_pkg::psm_result_t push_data,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output psm_pkg::psm_result_t      out_data
);
    import psm_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    psm_result_t out_data_reg;
    psm_result_t skid_data_reg;

    // Control: the output stage drains into the consumer, the skid stage refills it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            if (out_valid_reg && !out_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_valid_reg && out_ready) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers follow the same decisions without reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            if (out_valid_reg && !out_ready) begin
                skid_data_reg <= push_data;
            end else begin
                out_data_reg <= push_data;
            end
        end else if (out_valid_reg && out_ready && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== sv/pattern_substring_matcher.sv =====
`default_nettype none

// Channel   | Handshake        | Payload
// ----------+------------------+-----------------------------------------------
// input     | s_valid/s_ready  | s_text_byte, s_text_start
// result    | m_valid/m_ready  | m_match_found, m_match_start, m_position_overflow
// config    | cfg_write_en     | cfg_index, cfg_data (no wait, no read-back)
//
// One text byte is taken per cycle while s_ready is high; its result is registered
// in the output buffer. The window is a row of MAX_PAT cells that shift one byte
// per transfer and compare in parallel, so the whole pattern is checked at once.
// A two-entry output buffer keeps input ready high while one result waits.
// Reset (synchronous, active low) clears the window, the position counter, and
// the pattern registers (length 1, bytes zero). No clearing pass is needed.

module pattern_substring_matcher #(
    parameter int unsigned MAX_PAT  = 32,
    parameter int unsigned MAX_TEXT = 65536
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_write_en,
    input  wire logic [psm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [psm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [psm_pkg::BYTE_W-1:0]      s_text_byte,
    input  wire logic                            s_text_start,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_match_found,
    output logic      [psm_pkg::START_W-1:0]     m_match_start,
    output logic                                 m_position_overflow
);
    import psm_pkg::*;

    localparam int unsigned LW     = $clog2(MAX_PAT + 1);
    localparam int unsigned SEEN_W = $clog2(MAX_TEXT + 1);

    logic [LEN_W-1:0]      pat_len_reg;
    logic [CFG_DATA_W-1:0] pat_regs_reg [NUM_PAT_REGS];
    logic [PAT_BITS_W-1:0] pat_bits;
    logic [LW-1:0]         eff_len;
    logic [SEEN_W-1:0]     seen_reg;
    logic [SEEN_W-1:0]     seen_next;
    logic [SEEN_W-1:0]     pos;
    logic [SEEN_W-1:0]     pos_plus;
    logic [SEEN_W-1:0]     start_full;
    logic                  over;
    logic                  found;
    logic                  accept;
    logic [BYTE_W-1:0]     window [MAX_PAT];
    logic [MAX_PAT-1:0]    hits;
    cell_ctl_t             cell_ctl [MAX_PAT];
    psm_result_t           result;
    psm_result_t           m_data;

    assign accept = s_valid && s_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_len_reg <= LEN_W'(1);
            for (int r = 0; r < NUM_PAT_REGS; r++) begin
                pat_regs_reg[r] <= '0;
            end
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                CFG_PAT_LENGTH: pat_len_reg     <= cfg_data[LEN_W-1:0];
                CFG_PAT_0_7:    pat_regs_reg[0] <= cfg_data;
                CFG_PAT_8_15:   pat_regs_reg[1] <= cfg_data;
                CFG_PAT_16_23:  pat_regs_reg[2] <= cfg_data;
                CFG_PAT_24_31:  pat_regs_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pat_bits = {pat_regs_reg[3], pat_regs_reg[2], pat_regs_reg[1], pat_regs_reg[0]};

    // Length in use, limited to the window depth.
    always_comb begin
        if ({1'b0, pat_len_reg} > (LEN_W + 1)'(MAX_PAT)) begin
            eff_len = LW'(MAX_PAT);
        end else begin
            eff_len = LW'(pat_len_reg);
        end
    end

    // Row of window cells; cell k holds the byte k positions back.
    for (genvar k = 0; k < MAX_PAT; k++) begin : g_cell
        localparam logic [LW-1:0] KL = LW'(k);
        logic [BYTE_W-1:0] d_in;
        logic [LW-1:0]     pat_idx;
        logic [BYTE_W-1:0] pat_sel;
        logic              in_use;

        if (k == 0) begin : g_head
            assign d_in = s_text_byte;
        end else begin : g_body
            assign d_in = window[k-1];
        end

        assign cell_ctl[k].shift = accept;
        assign cell_ctl[k].flush = (k != 0) && s_text_start;
        assign in_use  = KL < eff_len;
        assign pat_idx = eff_len - KL - LW'(1);
        assign pat_sel = pat_byte(pat_bits, PAT_IDX_W'(pat_idx));

        psm_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (cell_ctl[k]),
            .d_in    (d_in),
            .pat     (pat_sel),
            .in_use  (in_use),
            .q_out   (window[k]),
            .hit     (hits[k])
        );
    end

    // Position tracking and match decision for the byte being transferred.
    always_comb begin
        pos        = s_text_start ? '0 : seen_reg;
        over       = pos >= SEEN_W'(MAX_TEXT);
        pos_plus   = pos + SEEN_W'(1);
        seen_next  = over ? SEEN_W'(MAX_TEXT) : pos_plus;
        start_full = pos_plus - SEEN_W'(eff_len);
        found      = !over && (eff_len != '0) && (pos_plus >= SEEN_W'(eff_len)) && (&hits);

        result.match_found       = found;
        result.match_start       = found ? START_W'(start_full) : '0;
        result.position_overflow = over;
    end

    // Byte counter for the current text.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else if (accept) begin
            seen_reg <= seen_next;
        end
    end

    // Output stage with skid entry.
    psm_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (result),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    assign m_match_found       = m_data.match_found;
    assign m_match_start       = m_data.match_start;
    assign m_position_overflow = m_data.position_overflow;

    // A result past the counter's range never reports a match.
    a_no_match_on_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_match_found && m_position_overflow))
        else $error("match reported on an overflowed position");

    // The counter saturates at the text limit.
    a_seen_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= SEEN_W'(MAX_TEXT))
        else $error("byte counter beyond its limit");

    // A new text restarts counting at its first byte.
    a_start_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_text_start) |=> (seen_reg == SEEN_W'(1)))
        else $error("start flag did not restart the byte counter");

    // Once saturated, the counter stays put until a new text begins.
    a_saturation_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_text_start && (seen_reg == SEEN_W'(MAX_TEXT)))
        |=> (seen_reg == SEEN_W'(MAX_TEXT)))
        else $error("saturated byte counter moved");

endmodule

`default_nettype wire
